// ----- hw/rtl/lexnt_pkg.sv -----
// ----------------------------------------------------------------------------
// lexnt_pkg
// Shared types, constants and character and keyword helper functions for the lexer with name table.
// ----------------------------------------------------------------------------
`default_nettype none

package lexnt_pkg;

    localparam logic [3:0] TK_BEGIN    = 4'd0;
    localparam logic [3:0] TK_END      = 4'd1;
    localparam logic [3:0] TK_SYMBOL   = 4'd2;
    localparam logic [3:0] TK_NUMBER   = 4'd3;
    localparam logic [3:0] TK_KEYWORD  = 4'd4;
    localparam logic [3:0] TK_IDENT    = 4'd5;
    localparam logic [3:0] TK_INVALID  = 4'd6;
    localparam logic [3:0] TK_EOF      = 4'd7;
    localparam logic [3:0] TK_OVERFLOW = 4'd8;
    localparam logic [3:0] TK_TOOLONG  = 4'd9;

    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_NUM  = 2'd1;
    localparam logic [1:0] MODE_WORD = 2'd2;
    localparam logic [1:0] MODE_LONG = 2'd3;

    localparam int unsigned NUM_KW = 9;
    localparam int unsigned KW_MAX = 6;
    localparam logic [30:0] NUM_MAX = 31'h7FFF_FFFF;

    typedef logic [7:0] byte_t;

    typedef struct packed {
        logic [3:0]  kind;
        logic [30:0] value;
    } token_t;

    function automatic logic [2:0] kw_len(input logic [3:0] k);
        logic [2:0] r;
        begin
            unique case (k)
                4'd0: r = 3'd2;
                4'd1: r = 3'd4;
                4'd2: r = 3'd5;
                4'd3: r = 3'd2;
                4'd4: r = 3'd6;
                4'd5: r = 3'd4;
                4'd6: r = 3'd5;
                4'd7: r = 3'd3;
                4'd8: r = 3'd5;
                default: r = 3'd0;
            endcase
            return r;
        end
    endfunction

    function automatic byte_t kw_char(input logic [3:0] k, input logic [2:0] i);
        logic [47:0] s;
        begin
            unique case (k)
                4'd0: s = "if    ";
                4'd1: s = "then  ";
                4'd2: s = "while ";
                4'd3: s = "do    ";
                4'd4: s = "return";
                4'd5: s = "read  ";
                4'd6: s = "print ";
                4'd7: s = "int   ";
                4'd8: s = "const ";
                default: s = '0;
            endcase
            return s[8'(47 - 8 * 32'(i)) -: 8];
        end
    endfunction

    function automatic logic is_digit(input byte_t c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_letter(input byte_t c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_space(input byte_t c);
        return c == " " || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_op(input byte_t c);
        return c == "(" || c == ")" || c == "," || c == ";" || c == "=" ||
               c == "+" || c == "-" || c == "*" || c == "/" || c == "%";
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/lexnt_out.sv -----
// ----------------------------------------------------------------------------
// lexnt_out
// Output register holding one token beat toward the receiver.
// ----------------------------------------------------------------------------
`default_nettype none

module lexnt_out
    import lexnt_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    input  wire token_t      tok,
    input  wire logic        last,
    output logic             full,
    output logic             valid,
    input  wire logic        stall,
    output logic [3:0]       token_kind,
    output logic [30:0]      token_value,
    output logic             last_of_run
);

    logic   valid_reg;
    token_t tok_reg;
    logic   last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (push)
        begin
            valid_reg <= 1'b1;
        end
        else if (!stall)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            tok_reg  <= tok;
            last_reg <= last;
        end
    end

    assign full        = valid_reg && stall;
    assign valid       = valid_reg;
    assign token_kind  = tok_reg.kind;
    assign token_value = tok_reg.value;
    assign last_of_run = last_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/lexer_with_name_table_top.sv -----
// ----------------------------------------------------------------------------
// lexer_with_name_table_top
// Character-serial lexer with keyword match and a byte-wide name table.
// ----------------------------------------------------------------------------
// Input channel: one character or end-of-text beat (in_valid / in_stall).
// Output channel: token beats (out_valid / out_stall); last_of_run marks the
// final token caused by one input beat. An input beat gives 0, 1 or 2 tokens.
// Ending a word runs a sequencer over one byte compare unit: keyword scan,
// then, if no keyword matches, a byte-wise walk of the name table, then,
// for a new name that fits, an append. The worst case is set by the table
// walk and the append.
// in_stall stays high until all tokens of a beat sit in the output
// register; out_stall holds the output register and the sequencer waits.
// Reset empties the name table (fill count cleared) and returns to idle.
// The name table is a RAM with one write and one read port; its contents need no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module lexer_with_name_table_top
    import lexnt_pkg::*;
#(
    parameter int unsigned TABLE_BYTES = 512,
    parameter int unsigned MAX_WORD    = 39
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  char_code,
    input  wire logic        end_of_text,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [3:0]       token_kind,
    output logic [30:0]      token_value,
    output logic             last_of_run
);

    localparam int TW = $clog2(TABLE_BYTES);
    localparam int FW = $clog2(TABLE_BYTES + 1);
    localparam int WW = $clog2(MAX_WORD);
    localparam int LW = $clog2(MAX_WORD + 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DISP  = 4'd1;
    localparam logic [3:0] S_KW    = 4'd2;
    localparam logic [3:0] S_TRD   = 4'd3;
    localparam logic [3:0] S_TCMP  = 4'd4;
    localparam logic [3:0] S_APP   = 4'd5;
    localparam logic [3:0] S_EMIT1 = 4'd6;
    localparam logic [3:0] S_EMIT2 = 4'd7;
    localparam logic [3:0] S_WRD   = 4'd8;

    logic [3:0]    state_reg, state_next;
    logic [1:0]    mode_reg;
    logic [30:0]   acc_reg;
    logic [LW-1:0] len_reg;
    logic [FW-1:0] fill_reg;
    byte_t         c_reg;
    logic          eot_reg;
    token_t        t1_reg, t2_reg;
    logic          has2_reg;
    logic [3:0]    kw_reg;
    logic [2:0]    ki_reg;
    logic          kok_reg;
    logic [FW-1:0] pos_reg, ent_reg;
    logic [LW-1:0] wi_reg;
    logic          wok_reg;
    byte_t         tbl_q, wb_q;

    byte_t         word_mem [MAX_WORD];
    byte_t         name_mem [TABLE_BYTES];

    logic          push;
    token_t        push_tok;
    logic          push_last;
    logic          ofull;

    lexnt_out u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .tok         (push_tok),
        .last        (push_last),
        .full        (ofull),
        .valid       (out_valid),
        .stall       (out_stall),
        .token_kind  (token_kind),
        .token_value (token_value),
        .last_of_run (last_of_run)
    );

    assign in_stall = (state_reg != S_IDLE);
    wire accept = in_valid && !in_stall;

    // the single compare unit: word byte against a keyword or table byte
    byte_t cmp_a, cmp_b;
    wire   cmp_eq = (cmp_a == cmp_b);

    // number step: acc*10+d with saturation
    wire [34:0] num_mul = {acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0}
                          + 35'(c_reg - "0");
    wire [30:0] num_sat = (num_mul > 35'(NUM_MAX)) ? NUM_MAX : num_mul[30:0];

    wire [LW-1:0] wb_addr_w = (state_reg == S_KW) ? LW'(ki_reg) : wi_reg;

    always_comb
    begin
        cmp_a = wb_q;
        cmp_b = tbl_q;
        if (state_reg == S_KW)
        begin
            cmp_b = kw_char(kw_reg, ki_reg - 3'd1);
        end
    end

    // word buffer RAM
    always_ff @(posedge clk)
    begin
        if (accept && !end_of_text && is_letter(char_code) &&
            (mode_reg == MODE_IDLE || mode_reg == MODE_NUM))
        begin
            word_mem[0] <= char_code;
        end
        else if (state_reg == S_DISP && mode_reg == MODE_WORD && !eot_reg &&
                 (is_digit(c_reg) || is_letter(c_reg)) && len_reg < LW'(MAX_WORD))
        begin
            word_mem[len_reg[WW-1:0]] <= c_reg;
        end
        wb_q <= word_mem[wb_addr_w[WW-1:0]];
    end

    // name table RAM: append writes, walk reads
    wire          app_wr   = (state_reg == S_APP);
    wire [FW-1:0] app_addr = fill_reg + FW'(wi_reg);
    wire          app_zero = (wi_reg == len_reg);
    wire [FW-1:0] rd_addr  = ent_reg;

    always_ff @(posedge clk)
    begin
        if (app_wr)
        begin
            name_mem[app_addr[TW-1:0]] <= app_zero ? 8'd0 : wb_q;
        end
        tbl_q <= name_mem[rd_addr[TW-1:0]];
    end

    always_comb
    begin
        push      = 1'b0;
        push_tok  = t1_reg;
        push_last = !has2_reg;
        if (state_reg == S_EMIT1 && !ofull)
        begin
            push = 1'b1;
        end
        else if (state_reg == S_EMIT2 && !ofull)
        begin
            push      = 1'b1;
            push_tok  = t2_reg;
            push_last = 1'b1;
        end
    end

    function automatic token_t own_tok(input byte_t c, input logic eot);
        token_t t;
        begin
            t.value = '0;
            priority if (eot)
                t.kind = TK_EOF;
            else if (c == "{")
                t.kind = TK_BEGIN;
            else if (c == "}")
                t.kind = TK_END;
            else if (is_op(c))
            begin
                t.kind  = TK_SYMBOL;
                t.value = 31'(c);
            end
            else
            begin
                t.kind  = TK_INVALID;
                t.value = 31'(c);
            end
            return t;
        end
    endfunction

    wire own_none = !eot_reg && (is_space(c_reg) || is_digit(c_reg) || is_letter(c_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            mode_reg  <= MODE_IDLE;
            acc_reg   <= '0;
            len_reg   <= '0;
            fill_reg  <= '0;
            c_reg     <= '0;
            eot_reg   <= 1'b0;
            t1_reg    <= '0;
            t2_reg    <= '0;
            has2_reg  <= 1'b0;
            kw_reg    <= '0;
            ki_reg    <= '0;
            kok_reg   <= 1'b0;
            pos_reg   <= '0;
            ent_reg   <= '0;
            wi_reg    <= '0;
            wok_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        c_reg   <= char_code;
                        eot_reg <= end_of_text;
                    end
                end
                S_DISP:
                begin
                    if (!eot_reg && mode_reg == MODE_NUM && is_digit(c_reg))
                    begin
                        acc_reg <= num_sat;
                    end
                    else if (!eot_reg && (mode_reg == MODE_WORD || mode_reg == MODE_LONG)
                             && (is_digit(c_reg) || is_letter(c_reg)))
                    begin
                        if (mode_reg == MODE_WORD)
                        begin
                            if (len_reg < LW'(MAX_WORD))
                                len_reg <= len_reg + 1'b1;
                            else
                                mode_reg <= MODE_LONG;
                        end
                    end
                    else
                    begin
                        // flush pending token, then classify own character
                        t2_reg <= own_tok(c_reg, eot_reg);
                        if (!eot_reg && is_digit(c_reg))
                        begin
                            mode_reg <= MODE_NUM;
                            acc_reg  <= 31'(c_reg - "0");
                        end
                        else if (!eot_reg && is_letter(c_reg))
                        begin
                            mode_reg <= MODE_WORD;
                            acc_reg  <= '0;
                        end
                        else
                        begin
                            mode_reg <= MODE_IDLE;
                            acc_reg  <= '0;
                        end
                        unique case (mode_reg)
                            MODE_NUM:
                            begin
                                t1_reg   <= '{kind: TK_NUMBER, value: acc_reg};
                                has2_reg <= !own_none;
                            end
                            MODE_LONG:
                            begin
                                t1_reg   <= '{kind: TK_TOOLONG, value: '0};
                                has2_reg <= !own_none;
                            end
                            MODE_WORD:
                            begin
                                has2_reg <= !own_none;
                                kw_reg   <= '0;
                                ki_reg   <= '0;
                                kok_reg  <= 1'b1;
                            end
                            default:
                            begin
                                t1_reg   <= own_tok(c_reg, eot_reg);
                                has2_reg <= 1'b0;
                            end
                        endcase
                        if (!(mode_reg == MODE_WORD) && !eot_reg && is_letter(c_reg))
                            len_reg <= LW'(1);
                    end
                end
                S_KW:
                begin
                    // ki counts bytes; compare result of byte ki-1 arrives now
                    if (LW'(kw_len(kw_reg)) != len_reg ||
                        (ki_reg != 3'd0 && !cmp_eq) ||
                        ki_reg == kw_len(kw_reg))
                    begin
                        if (LW'(kw_len(kw_reg)) == len_reg && ki_reg == kw_len(kw_reg)
                            && kok_reg && (ki_reg == 3'd0 || cmp_eq))
                        begin
                            t1_reg <= '{kind: TK_KEYWORD, value: 31'(kw_reg)};
                        end
                        else
                        begin
                            kw_reg  <= kw_reg + 1'b1;
                            ki_reg  <= '0;
                            kok_reg <= 1'b1;
                            pos_reg <= '0;
                            ent_reg <= '0;
                            wi_reg  <= '0;
                            wok_reg <= 1'b1;
                        end
                    end
                    else
                    begin
                        ki_reg <= ki_reg + 1'b1;
                    end
                end
                S_TRD:
                begin
                    // table byte at ent and word byte at wi are being read
                end
                S_TCMP:
                begin
                    if (tbl_q == 8'd0)
                    begin
                        if (wok_reg && wi_reg == len_reg)
                        begin
                            t1_reg <= '{kind: TK_IDENT, value: 31'(pos_reg)};
                        end
                        else
                        begin
                            pos_reg <= ent_reg + 1'b1;
                            ent_reg <= ent_reg + 1'b1;
                            wi_reg  <= '0;
                            wok_reg <= 1'b1;
                            if (ent_reg + 1'b1 >= fill_reg)
                            begin
                                if (32'(fill_reg) + 32'(len_reg) + 1 > TABLE_BYTES)
                                    t1_reg <= '{kind: TK_OVERFLOW, value: '0};
                            end
                        end
                    end
                    else
                    begin
                        if (wi_reg == len_reg || !cmp_eq)
                            wok_reg <= 1'b0;
                        if (wi_reg != len_reg)
                            wi_reg <= wi_reg + 1'b1;
                        ent_reg <= ent_reg + 1'b1;
                    end
                end
                S_WRD:
                begin
                end
                S_APP:
                begin
                    if (app_zero)
                    begin
                        t1_reg   <= '{kind: TK_IDENT, value: 31'(fill_reg)};
                        fill_reg <= fill_reg + FW'(len_reg) + 1'b1;
                    end
                    else
                        wi_reg <= wi_reg + 1'b1;
                end
                S_EMIT1:
                begin
                    if (!ofull)
                    begin
                        mode_reg <= mode_reg;
                    end
                end
                S_EMIT2:
                begin
                end
                default:
                begin
                end
            endcase
        end
    end

    wire word_flush = !(( !eot_reg && mode_reg == MODE_NUM && is_digit(c_reg)) ||
                        (!eot_reg && (mode_reg == MODE_WORD || mode_reg == MODE_LONG)
                         && (is_digit(c_reg) || is_letter(c_reg))));
    wire kw_done = (LW'(kw_len(kw_reg)) != len_reg) ||
                   (ki_reg != 3'd0 && !cmp_eq) || ki_reg == kw_len(kw_reg);
    wire kw_hit  = (LW'(kw_len(kw_reg)) == len_reg) && ki_reg == kw_len(kw_reg)
                   && kok_reg && (ki_reg == 3'd0 || cmp_eq);
    wire fits    = (32'(fill_reg) + 32'(len_reg) + 1 <= TABLE_BYTES);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (accept) state_next = S_DISP;
            S_DISP:
            begin
                if (!word_flush)
                    state_next = S_IDLE;
                else if (mode_reg == MODE_WORD)
                    state_next = S_KW;
                else if (mode_reg == MODE_IDLE && own_none)
                    state_next = S_IDLE;
                else
                    state_next = S_EMIT1;
            end
            S_KW:
            begin
                if (kw_done)
                begin
                    if (kw_hit)
                        state_next = S_EMIT1;
                    else if (kw_reg == 4'(NUM_KW - 1))
                        state_next = (fill_reg == '0) ? (fits ? S_WRD : S_EMIT1) : S_TRD;
                end
            end
            S_TRD:   state_next = S_TCMP;
            S_TCMP:
            begin
                if (tbl_q == 8'd0)
                begin
                    if (wok_reg && wi_reg == len_reg)
                        state_next = S_EMIT1;
                    else if (ent_reg + 1'b1 >= fill_reg)
                        state_next = fits ? S_WRD : S_EMIT1;
                    else
                        state_next = S_TRD;
                end
                else
                    state_next = S_TRD;
            end
            S_WRD:   state_next = S_APP;
            S_APP:   state_next = app_zero ? S_EMIT1 : S_WRD;
            S_EMIT1: if (!ofull) state_next = has2_reg ? S_EMIT2 : S_IDLE;
            S_EMIT2: if (!ofull) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

endmodule

`default_nettype wire

// ----- tb/lexer_with_name_table_top_test.sv -----
// ----------------------------------------------------------------------------
// lexer_with_name_table_top_test
// Feeds character and end-of-text beats to the lexer, predicts every token
// from a behavioral model of the scanner and name table, and checks each
// output beat in order. Random idling on both sides, one long output hold-off
// and drain pauses between phases.
// ----------------------------------------------------------------------------
`default_nettype none

module lexer_with_name_table_top_test
    import lexnt_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned TBL_BYTES = 512;
    localparam int unsigned WORD_MAX  = 39;

    typedef struct packed {
        logic [3:0]  kind;
        logic [30:0] value;
        logic        last;
    } tok_beat_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       eot;
    } char_beat_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  char_code;
    logic        end_of_text;
    logic        out_valid;
    logic        out_stall;
    logic [3:0]  token_kind;
    logic [30:0] token_value;
    logic        last_of_run;

    lexer_with_name_table_top #(.TABLE_BYTES(TBL_BYTES), .MAX_WORD(WORD_MAX)) dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .char_code(char_code), .end_of_text(end_of_text),
        .out_valid(out_valid), .out_stall(out_stall),
        .token_kind(token_kind), .token_value(token_value), .last_of_run(last_of_run)
    );

    // scanner model state
    logic [1:0]  lx_mode;
    logic [30:0] lx_num;
    logic [7:0]  lx_word [WORD_MAX];
    int unsigned lx_wlen;
    logic [7:0]  lx_table [TBL_BYTES];
    int unsigned lx_fill;

    char_beat_t pending_chars[$];
    tok_beat_t  expected_tokens[$];
    int         errors = 0;
    bit         quiet = 0;
    bit         hold_req = 0;
    int         hold_cycles = 0;
    int         in_gap = 0;
    int         out_gap = 0;

    string kw_names[9] = '{"if", "then", "while", "do", "return", "read",
                           "print", "int", "const"};

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic void push_token(logic [3:0] k, logic [30:0] v);
        tok_beat_t t;
        t.kind = k;
        t.value = v;
        t.last = 1'b0;
        expected_tokens.push_back(t);
    endfunction

    function automatic void close_word();
        int unsigned p;
        int unsigned e;
        bit hit;
        for (int k = 0; k < 9; k++)
        begin
            if (kw_names[k].len() == lx_wlen)
            begin
                hit = 1'b1;
                for (int i = 0; i < lx_wlen; i++)
                    if (lx_word[i] != kw_names[k][i]) hit = 1'b0;
                if (hit)
                begin
                    push_token(TK_KEYWORD, 31'(k));
                    return;
                end
            end
        end
        p = 0;
        while (p < lx_fill)
        begin
            e = p;
            while (e < lx_fill && lx_table[e] != 8'd0) e++;
            if (e - p == lx_wlen)
            begin
                hit = 1'b1;
                for (int i = 0; i < lx_wlen; i++)
                    if (lx_table[p + i] != lx_word[i]) hit = 1'b0;
                if (hit)
                begin
                    push_token(TK_IDENT, 31'(p));
                    return;
                end
            end
            p = e + 1;
        end
        if (lx_fill + lx_wlen + 1 > TBL_BYTES)
        begin
            push_token(TK_OVERFLOW, '0);
            return;
        end
        for (int i = 0; i < lx_wlen; i++) lx_table[lx_fill + i] = lx_word[i];
        lx_table[lx_fill + lx_wlen] = 8'd0;
        push_token(TK_IDENT, 31'(lx_fill));
        lx_fill += lx_wlen + 1;
    endfunction

    function automatic void close_pending();
        if (lx_mode == MODE_NUM) push_token(TK_NUMBER, lx_num);
        else if (lx_mode == MODE_WORD) close_word();
        else if (lx_mode == MODE_LONG) push_token(TK_TOOLONG, '0);
        lx_mode = MODE_IDLE;
        lx_num = '0;
        lx_wlen = 0;
    endfunction

    function automatic void scan_char(char_beat_t b);
        int unsigned n0;
        logic [7:0] c;
        logic [34:0] v;
        n0 = expected_tokens.size();
        c = b.ch;
        if (b.eot)
        begin
            close_pending();
            push_token(TK_EOF, '0);
        end
        else if (lx_mode == MODE_NUM && is_digit(c))
        begin
            v = 35'(lx_num) * 10 + 35'(c - "0");
            lx_num = (v > 35'(NUM_MAX)) ? NUM_MAX : v[30:0];
        end
        else if ((lx_mode == MODE_WORD || lx_mode == MODE_LONG) &&
                 (is_digit(c) || is_letter(c)))
        begin
            if (lx_mode == MODE_WORD)
            begin
                if (lx_wlen < WORD_MAX)
                begin
                    lx_word[lx_wlen] = c;
                    lx_wlen++;
                end
                else lx_mode = MODE_LONG;
            end
        end
        else
        begin
            close_pending();
            if (is_space(c)) ;
            else if (is_digit(c))
            begin
                lx_mode = MODE_NUM;
                lx_num = 31'(c - "0");
            end
            else if (is_letter(c))
            begin
                lx_mode = MODE_WORD;
                lx_word[0] = c;
                lx_wlen = 1;
            end
            else if (c == "{") push_token(TK_BEGIN, '0);
            else if (c == "}") push_token(TK_END, '0);
            else if (is_op(c)) push_token(TK_SYMBOL, 31'(c));
            else push_token(TK_INVALID, 31'(c));
        end
        if (expected_tokens.size() > n0)
            expected_tokens[expected_tokens.size() - 1].last = 1'b1;
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            char_code <= 8'd0;
            end_of_text <= 1'b0;
            in_gap <= 0;
        end
        else if (!(in_valid && in_stall))
        begin
            if (in_gap > 0)
            begin
                in_gap <= in_gap - 1;
                in_valid <= 1'b0;
            end
            else if (pending_chars.size() > 0)
            begin
                char_beat_t b;
                b = pending_chars.pop_front();
                scan_char(b);
                char_code <= b.ch;
                end_of_text <= b.eot;
                in_valid <= 1'b1;
                if (!quiet && $urandom_range(0, 9) == 0) in_gap <= $urandom_range(1, 13);
            end
            else
                in_valid <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            out_gap <= 0;
            hold_cycles <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_tokens.size() == 0)
                begin
                    $error("token with none expected: kind %0d value %0d",
                           token_kind, token_value);
                    errors++;
                end
                else
                begin
                    tok_beat_t t;
                    t = expected_tokens.pop_front();
                    if (token_kind !== t.kind)
                    begin
                        $error("token_kind expected %0d actual %0d", t.kind, token_kind);
                        errors++;
                    end
                    if (token_value !== t.value)
                    begin
                        $error("token_value expected %0d actual %0d", t.value, token_value);
                        errors++;
                    end
                    if (last_of_run !== t.last)
                    begin
                        $error("last_of_run expected %0d actual %0d", t.last, last_of_run);
                        errors++;
                    end
                end
            end
            if (hold_req && hold_cycles == 0) hold_cycles <= 3000;
            if (hold_cycles > 0)
            begin
                hold_cycles <= hold_cycles - 1;
                out_stall <= 1'b1;
            end
            else if (out_gap > 0)
            begin
                out_gap <= out_gap - 1;
                out_stall <= 1'b1;
            end
            else if (!quiet && $urandom_range(0, 9) == 0)
            begin
                out_gap <= $urandom_range(0, 12);
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    task automatic add_char(logic [7:0] c);
        char_beat_t b;
        b.ch = c;
        b.eot = 1'b0;
        pending_chars.push_back(b);
    endtask

    task automatic add_eot(logic [7:0] c);
        char_beat_t b;
        b.ch = c;
        b.eot = 1'b1;
        pending_chars.push_back(b);
    endtask

    task automatic add_text(string s);
        for (int i = 0; i < s.len(); i++) add_char(s[i]);
    endtask

    function automatic logic [7:0] any_letter();
        return $urandom_range(0, 1) ? 8'($urandom_range("a", "z"))
                                    : 8'($urandom_range("A", "Z"));
    endfunction

    function automatic logic [7:0] any_alnum();
        int r;
        r = $urandom_range(0, 2);
        if (r == 0) return 8'($urandom_range("0", "9"));
        return any_letter();
    endfunction

    function automatic logic [7:0] any_sep();
        string seps;
        seps = " \t\n\v\f\r{}(),;=+-*/%#";
        if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
        return seps[$urandom_range(0, seps.len() - 1)];
    endfunction

    task automatic wait_drain();
        while (pending_chars.size() > 0 || in_valid || expected_tokens.size() > 0)
            @(posedge clk);
        repeat (700) @(posedge clk);
    endtask

    task automatic add_random(int count);
        int n;
        int len;
        n = 0;
        while (n < count)
        begin
            int r;
            r = $urandom_range(0, 19);
            if (r < 8)
            begin
                len = ($urandom_range(0, 15) == 0) ? $urandom_range(38, 45)
                                                   : $urandom_range(1, 5);
                add_char(any_letter());
                for (int i = 1; i < len; i++) add_char(any_alnum());
                n += len;
            end
            else if (r < 10)
            begin
                add_text(kw_names[$urandom_range(0, 8)]);
                n += 3;
            end
            else if (r < 14)
            begin
                len = $urandom_range(1, 12);
                for (int i = 0; i < len; i++) add_char(8'($urandom_range("0", "9")));
                n += len;
            end
            else if (r == 14)
            begin
                add_eot(8'($urandom_range(0, 255)));
                n++;
            end
            else if (r == 15)
            begin
                add_char(8'($urandom_range(0, 255)));
                n++;
            end
            add_char(any_sep());
            n++;
        end
    endtask

    initial begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        char_code = 8'd0;
        end_of_text = 1'b0;
        out_stall = 1'b0;
        lx_mode = MODE_IDLE;
        lx_num = '0;
        lx_wlen = 0;
        lx_fill = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        // directed
        add_text("{if x1=2147483648;}");
        add_char(8'h00);
        add_char(8'hFF);
        add_char(8'h80);
        add_text("x1 Int\t");
        add_eot(8'hFF);
        for (int i = 0; i < 41; i++) add_char("a");
        add_text("(q)");
        add_text("then while do return read print int const, 7%");
        add_char(8'h7F);
        add_eot(8'h00);
        // fill up the output side while input keeps coming
        hold_req = 1'b1;
        add_random(120);
        repeat (3) @(posedge clk);
        hold_req = 1'b0;
        // pause input until all tokens are out
        wait_drain();
        add_random(150);
        wait_drain();
        // fill the name table with distinct long names to reach overflow
        for (int w = 0; w < 14; w++)
        begin
            add_char("z");
            for (int i = 0; i < 37; i++) add_char(any_alnum());
            add_char(" ");
        end
        wait_drain();
        add_random(100);
        wait_drain();
        quiet = 1'b1;
        add_random(100);
        add_eot(" ");
        wait_drain();
        if (errors == 0)
            $display("[lexer_with_name_table_top] OK");
        else
            $display("[lexer_with_name_table_top] ERROR");
        $finish;
    end

    initial begin
        #200ms;
        $display("[lexer_with_name_table_top] ERROR");
        $finish;
    end

endmodule

`default_nettype wire
